// ===== design/bamp_pkg.sv =====
// ----------------------------------------------------------------------------
// bamp_pkg : shared types and constants for the boot argument address parser
// Status codes, per-key summary struct and the character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bamp_pkg;

    localparam int ADDR_W = 48;   // width of one captured address
    localparam int CHAR_W = 8;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_MAC1_MISSING = 3'd1,
        STATUS_MAC1_BAD    = 3'd2,
        STATUS_MAC2_MISSING = 3'd3,
        STATUS_MAC2_BAD    = 3'd4
    } status_t;

    // Summary of one key tracker after the current item
    typedef struct packed {
        logic              found;
        logic              good;
        logic [ADDR_W-1:0] addr;
    } key_info_t;

    // Decoded hex digit
    typedef struct packed {
        logic       bad;
        logic [3:0] val;
    } hex_t;

    localparam logic [CHAR_W-1:0] CHAR_M    = 8'h6D;   // 'm'
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h61;   // 'a'
    localparam logic [CHAR_W-1:0] CHAR_C    = 8'h63;   // 'c'
    localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;   // '1'
    localparam logic [CHAR_W-1:0] CHAR_TWO  = 8'h32;   // '2'

    // Character expected at a given position of the shared key prefix
    function automatic logic [CHAR_W-1:0] key_prefix(input logic [1:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            2'd0:    ch = CHAR_M;
            2'd1:    ch = CHAR_A;
            default: ch = CHAR_C;
        endcase
        return ch;
    endfunction

    // Hex digit decode, either case
    function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_t h;
        h.bad = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            h.val = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            h.val = 4'(c - 8'd55);
        else if (c >= 8'h61 && c <= 8'h66)
            h.val = 4'(c - 8'd87);
        else
            h.bad = 1'b1;
        return h;
    endfunction

endpackage : bamp_pkg

`default_nettype wire

// ===== design/bamp_in_reg.sv =====
// ----------------------------------------------------------------------------
// bamp_in_reg : input register
// Holds one accepted byte until the processing stage advances it.
// ----------------------------------------------------------------------------
`default_nettype none

module bamp_in_reg
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [bamp_pkg::CHAR_W-1:0] s_tdata,
    input  wire logic                       s_tlast,
    input  wire logic                       advance,
    output logic                            item_valid,
    output logic [bamp_pkg::CHAR_W-1:0]     item_char,
    output logic                            item_last
);
    import bamp_pkg::*;

    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              load;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item_char  = char_reg;
    assign item_last  = last_reg;

endmodule : bamp_in_reg

`default_nettype wire

// ===== design/bamp_key_unit.sv =====
// ----------------------------------------------------------------------------
// bamp_key_unit : one key tracker
// Match the key, capture the hex digits after it and build the address.
// ----------------------------------------------------------------------------
`default_nettype none

module bamp_key_unit
#(
    parameter logic [7:0] KEY_DIGIT = 8'h31,
    parameter int         CAP_END   = 19,
    parameter int         OFF_W     = 5
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic                        clear,
    input  wire logic [bamp_pkg::CHAR_W-1:0] char_in,
    output bamp_pkg::key_info_t              info
);
    import bamp_pkg::*;

    logic [2:0]        prog_reg,  prog_next;
    logic [OFF_W-1:0]  off_reg,   off_next;
    logic [1:0]        phase_reg, phase_next;
    logic              found_reg, found_next;
    logic              bad_reg,   bad_next;
    logic [ADDR_W-1:0] acc_reg,   acc_next;
    logic [2:0]        p;
    logic [CHAR_W-1:0] want;
    hex_t              hv;

    always_comb
    begin
        prog_next  = prog_reg;
        off_next   = off_reg;
        phase_next = phase_reg;
        found_next = found_reg;
        bad_next   = bad_reg;
        acc_next   = acc_reg;
        hv         = hex_decode(char_in);
        p          = (prog_reg > 3'd3) ? 3'd0 : prog_reg;
        want       = (p < 3'd3) ? key_prefix(p[1:0]) : KEY_DIGIT;

        if (step)
        begin
            // capture first: a key finishing now starts capturing on the next byte
            if (off_reg != '0 && off_reg < OFF_W'(CAP_END))
            begin
                if (off_reg >= OFF_W'(2) && phase_reg != 2'd2)
                begin
                    if (hv.bad)
                        bad_next = 1'b1;
                    else
                        acc_next = {acc_reg[ADDR_W-5:0], hv.val};
                end
                if (off_reg == OFF_W'(1) || phase_reg == 2'd2)
                    phase_next = 2'd0;
                else
                    phase_next = phase_reg + 2'd1;
                off_next = off_reg + OFF_W'(1);
            end

            if (!found_reg)
            begin
                if (char_in == want)
                    prog_next = p + 3'd1;
                else
                    prog_next = (char_in == CHAR_M) ? 3'd1 : 3'd0;
                if (prog_next == 3'd4)
                begin
                    found_next = 1'b1;
                    off_next   = OFF_W'(1);
                end
            end
        end

        info.found = found_next;
        info.good  = found_next && (off_next == OFF_W'(CAP_END)) && !bad_next;
        info.addr  = info.good ? acc_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg  <= '0;
            off_reg   <= '0;
            phase_reg <= '0;
            found_reg <= 1'b0;
            bad_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else if (clear)
        begin
            prog_reg  <= '0;
            off_reg   <= '0;
            phase_reg <= '0;
            found_reg <= 1'b0;
            bad_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            prog_reg  <= prog_next;
            off_reg   <= off_next;
            phase_reg <= phase_next;
            found_reg <= found_next;
            bad_reg   <= bad_next;
            acc_reg   <= acc_next;
        end
    end

endmodule : bamp_key_unit

`default_nettype wire

// ===== design/boot_arg_mac_address_parser_top.sv =====
// ----------------------------------------------------------------------------
// boot_arg_mac_address_parser_top : command-line address parser
// Scan a byte stream for the "mac1" and "mac2" keys and report both addresses.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) carries one command-line byte per item in s_tdata;
//   s_tlast marks the final byte. A zero byte ends the string, and bytes after
//   it are ignored up to the final one.
//   Master channel (m_*) carries one result item per command line, produced
//   for the item with s_tlast set: status plus the two 48-bit addresses.
//   Each key is tracked independently; an address reads as zero when its key
//   is missing, its hex digits are bad, or the string ends before all
//   digits arrive. Status checks mac1 before mac2.
//   Throughput: one item per cycle, unless a final byte waits for the output
//   register. Each byte passes the input register and then a single
//   combinational update of both key trackers, so the result for the final
//   byte is loaded into the output register as it leaves the input register.
//   Stalls: a waiting result sits in the output register; non-final bytes
//   keep flowing, and only a further final byte waits for the receiver.
//   Reset clears every tracker and the input and output valid flags; the
//   trackers and the string end marker also clear once a result is produced.
// ----------------------------------------------------------------------------
`default_nettype none

module boot_arg_mac_address_parser_top
#(
    parameter int ADDRESS_BYTES = 6
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] char_byte
    input  wire logic         s_tlast,   // is_last
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata    // [2:0] status, [50:3] first_address,
                                         // [98:51] second_address, rest zero
);
    import bamp_pkg::*;

    localparam int CAP_END = 3 * ADDRESS_BYTES + 1;
    localparam int OFF_W   = $clog2(CAP_END + 1);

    logic              item_valid;
    logic [CHAR_W-1:0] item_char;
    logic              item_last;
    logic              advance;
    logic              step;
    logic              clear;
    logic              ended_reg, ended_next;
    key_info_t         info_one, info_two;
    status_t           status_next;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg;
    logic [ADDR_W-1:0] first_reg, second_reg;

    bamp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item_char  (item_char),
        .item_last  (item_last)
    );

    // a final byte advances only when the output register can take its result
    assign advance = item_valid && (!item_last || !out_valid_reg || m_tready);
    assign step    = advance && !ended_reg && (item_char != '0);
    assign clear   = advance && item_last;

    bamp_key_unit #(
        .KEY_DIGIT (CHAR_ONE),
        .CAP_END   (CAP_END),
        .OFF_W     (OFF_W)
    ) u_key_one (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .clear   (clear),
        .char_in (item_char),
        .info    (info_one)
    );

    bamp_key_unit #(
        .KEY_DIGIT (CHAR_TWO),
        .CAP_END   (CAP_END),
        .OFF_W     (OFF_W)
    ) u_key_two (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .clear   (clear),
        .char_in (item_char),
        .info    (info_two)
    );

    // string end marker: set by a zero byte, dropped with the result
    always_comb
    begin
        ended_next = ended_reg;
        if (clear)
            ended_next = 1'b0;
        else if (advance && item_char == '0)
            ended_next = 1'b1;
    end

    // status priority: mac1 before mac2, missing before bad
    always_comb
    begin
        if (!info_one.found)
            status_next = STATUS_MAC1_MISSING;
        else if (!info_one.good)
            status_next = STATUS_MAC1_BAD;
        else if (!info_two.found)
            status_next = STATUS_MAC2_MISSING;
        else if (!info_two.good)
            status_next = STATUS_MAC2_BAD;
        else
            status_next = STATUS_OK;
    end

    // output register: load on a final byte, release when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (clear)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            status_reg <= status_next;
            first_reg  <= info_one.addr;
            second_reg <= info_two.addr;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, second_reg, first_reg, status_reg};

    // a missing or bad mac1 must never leak an address
    a_first_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (status_reg == STATUS_MAC1_MISSING || status_reg == STATUS_MAC1_BAD))
        |-> (first_reg == '0))
        else $error("first address not zero for failed mac1");

    // mac2 missing implies its address is zero
    a_second_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg == STATUS_MAC2_MISSING) |-> (second_reg == '0))
        else $error("second address not zero for missing mac2");

    // the string end marker is dropped once a result is produced
    a_ended_clear : assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> !ended_reg)
        else $error("string end marker survived a result");

endmodule : boot_arg_mac_address_parser_top

`default_nettype wire

// ===== tb/tb_boot_arg_mac_address_parser_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_boot_arg_mac_address_parser_top : self-checking bench for the parser
// Stream command lines into the parser a byte at a time. A bench-side copy of
// the key trackers predicts each report that is not written out by hand, and
// every report is compared field by field. A hand-written table of lines opens
// the run, and randomly built lines follow. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_boot_arg_mac_address_parser_top;

    import bamp_pkg::*;

    localparam int ADDRESS_BYTES  = 6;
    localparam int CAPTURE_DONE   = 3 * ADDRESS_BYTES + 1;   // offset once all chars are taken
    localparam int RANDOM_BYTES   = 820;
    localparam int MIN_LINES      = 15;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 8;

    // One report as the parser should produce it
    typedef struct packed {
        status_t     status;
        logic [47:0] first_addr;
        logic [47:0] second_addr;
    } mac_report_t;

    // One directed command line. A '^' in the text stands for a zero byte.
    // Where 'typed' is set, the report is written out here; otherwise the
    // predictor supplies it.
    typedef struct {
        string       text;
        bit          typed;
        mac_report_t report;
    } directed_line_t;

    directed_line_t directed_lines [15] = '{
        '{"x", 1'b1, '{STATUS_MAC1_MISSING, 48'h0, 48'h0}},
        '{"^", 1'b1, '{STATUS_MAC1_MISSING, 48'h0, 48'h0}},
        '{"mac1=ff:FF:ff:FF:ff:FF mac2=00-00-00-00-00-00", 1'b1,
          '{STATUS_OK, 48'hffff_ffff_ffff, 48'h0}},
        '{"mac1=09:af:AF:19:aF:0f,mac2=12345678901234567", 1'b1,
          '{STATUS_OK, 48'h09af_af19_af0f, 48'h1245_7801_3467}},
        '{"mac1=12:34:56:78:9a:bg mac2=00:00:00:00:00:00", 1'b1,
          '{STATUS_MAC1_BAD, 48'h0, 48'h0}},
        '{"mac1=12:34", 1'b1, '{STATUS_MAC1_BAD, 48'h0, 48'h0}},
        '{"mac1=12:34:56:78:9a:bc", 1'b1,
          '{STATUS_MAC2_MISSING, 48'h1234_5678_9abc, 48'h0}},
        '{"mac1=12:34:56:78:9a:bcmac2=01:02^mac2=01:02:03:04:05:06", 1'b1,
          '{STATUS_MAC2_BAD, 48'h1234_5678_9abc, 48'h0}},
        '{"mac2=aa:bb:cc:dd:ee:ff", 1'b1,
          '{STATUS_MAC1_MISSING, 48'h0, 48'haabb_ccdd_eeff}},
        '{"mac1=01:02:03:04:05:06 mac1=ff:ff:ff:ff:ff:ff mac2=10:20:30:40:50:60 mac2=1",
          1'b1, '{STATUS_OK, 48'h0102_0304_0506, 48'h1020_3040_5060}},
        '{"mmac1=0/:9:@:G`:g:af:AF mmac2 =:", 1'b0, '{STATUS_OK, 48'h0, 48'h0}},
        '{"mac2mac1=11:22:33:44:55:66mac2", 1'b0, '{STATUS_OK, 48'h0, 48'h0}},
        '{"ma^mac1=00:00:00:00:00:00\377\200", 1'b0, '{STATUS_OK, 48'h0, 48'h0}},
        '{"mac1:ab:cd:ef:01:23:45\377mac2=A0:B1:C2:D3:E4:F5", 1'b0,
          '{STATUS_OK, 48'h0, 48'h0}},
        '{"mac1=ab:cd:ef:01:23:4", 1'b0, '{STATUS_OK, 48'h0, 48'h0}}
    };

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;    // [7:0] char_byte
    logic         s_tlast = 1'b0;     // is_last
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;            // [2:0] status, [50:3] first_address,
                                      // [98:51] second_address, rest zero

    // Bench copy of the parser state, one slot per key
    logic [2:0]  key_progress [2];
    logic [4:0]  capture_offset [2];
    logic [47:0] address_acc [2];
    logic [1:0]  key_found;
    logic [1:0]  key_bad_hex;
    bit          line_ended;

    mac_report_t awaited_reports [$];
    int          error_count = 0;
    int          lines_sent = 0;
    int          bytes_sent = 0;
    int          reports_seen = 0;
    int          cycle_count = 0;
    bit          tx_idling = 1'b1;
    bit          rx_idling = 1'b1;
    int          rx_wait = 0;

    boot_arg_mac_address_parser_top #(
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abandon the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d reports still awaited",
                     $time, cycle_count, awaited_reports.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Hex digit value; bit 4 set marks a character that is not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [4:0] v;
        if (ch >= "0" && ch <= "9")
            v = 5'(ch - "0");
        else if (ch >= "A" && ch <= "F")
            v = 5'(ch - "A" + 10);
        else if (ch >= "a" && ch <= "f")
            v = 5'(ch - "a" + 10);
        else
            v = 5'h10;
        return v;
    endfunction

    task automatic clear_parser_state();
        for (int k = 0; k < 2; k++)
        begin
            key_progress[k]   = '0;
            capture_offset[k] = '0;
            address_acc[k]    = '0;
        end
        key_found   = '0;
        key_bad_hex = '0;
        line_ended  = 1'b0;
    endtask

    // Advance the bench trackers by one accepted byte; on the final byte
    // produce the report and start a fresh command line.
    task automatic scan_boot_byte(input logic [7:0] ch, input logic last,
                                  output bit has_report, output mac_report_t rep);
        logic [4:0] nib;
        int         pos;
        int         prog;
        logic [7:0] want;
        bit         good [2];
        has_report = 1'b0;
        rep        = '{STATUS_OK, 48'h0, 48'h0};
        if (!line_ended)
        begin
            if (ch == 8'h00)
                line_ended = 1'b1;
            else
            begin
                // Captures first, so a key completed on this byte starts on the next
                for (int k = 0; k < 2; k++)
                begin
                    if (capture_offset[k] != 0 && capture_offset[k] < CAPTURE_DONE)
                    begin
                        if (capture_offset[k] >= 2)
                        begin
                            pos = int'(capture_offset[k]) - 2;
                            if (pos % 3 != 2)
                            begin
                                nib = hex_nibble(ch);
                                if (nib[4])
                                    key_bad_hex[k] = 1'b1;
                                else
                                    address_acc[k] = {address_acc[k][43:0], nib[3:0]};
                            end
                        end
                        capture_offset[k] = capture_offset[k] + 5'd1;
                    end
                end
                for (int k = 0; k < 2; k++)
                begin
                    if (!key_found[k])
                    begin
                        prog = (key_progress[k] > 3) ? 0 : int'(key_progress[k]);
                        case (prog)
                            0:       want = "m";
                            1:       want = "a";
                            2:       want = "c";
                            default: want = (k == 0) ? "1" : "2";
                        endcase
                        if (ch == want)
                            prog = prog + 1;
                        else
                            prog = (ch == "m") ? 1 : 0;
                        if (prog == 4)
                        begin
                            key_found[k]      = 1'b1;
                            capture_offset[k] = 5'd1;
                        end
                        key_progress[k] = 3'(prog);
                    end
                end
            end
        end
        if (last)
        begin
            for (int k = 0; k < 2; k++)
                good[k] = key_found[k] && capture_offset[k] == CAPTURE_DONE && !key_bad_hex[k];
            if (!key_found[0])
                rep.status = STATUS_MAC1_MISSING;
            else if (!good[0])
                rep.status = STATUS_MAC1_BAD;
            else if (!key_found[1])
                rep.status = STATUS_MAC2_MISSING;
            else if (!good[1])
                rep.status = STATUS_MAC2_BAD;
            else
                rep.status = STATUS_OK;
            rep.first_addr  = good[0] ? address_acc[0] : 48'h0;
            rep.second_addr = good[1] ? address_acc[1] : 48'h0;
            has_report = 1'b1;
            clear_parser_state();
        end
    endtask

    // Push one command line through the slave channel, last byte flagged.
    // A typed report overrides the predicted one; the trackers advance either way.
    task automatic send_line(input logic [7:0] line_bytes [$], input bit typed,
                             input mac_report_t typed_report);
        int          gap;
        int          idx;
        logic        last;
        bit          has_report;
        mac_report_t rep;
        for (idx = 0; idx < line_bytes.size(); idx++)
        begin
            gap  = tx_idling ? $urandom_range(0, 9) : 0;
            last = (idx == line_bytes.size() - 1);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= line_bytes[idx];
            s_tlast  <= last;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            scan_boot_byte(line_bytes[idx], last, has_report, rep);
            if (has_report)
                awaited_reports.push_back(typed ? typed_report : rep);
            bytes_sent++;
        end
        lines_sent++;
        // Switch between idling and back-to-back stretches now and then
        if ($urandom_range(0, 4) == 0)
            tx_idling = !tx_idling;
    endtask

    // Build a random command line: mostly well-formed keys with random
    // addresses, mixed with noise, partial keys, corruption and truncation.
    task automatic compose_command_line(output logic [7:0] line_bytes [$]);
        int         parts;
        int         keep;
        int         sel;
        logic [3:0] nib;
        string      frag;
        line_bytes = {};
        parts = $urandom_range(1, 5);
        repeat (parts)
        begin
            sel = $urandom_range(0, 9);
            if (sel <= 5)
            begin
                frag = ($urandom_range(0, 1) == 0) ? "mac1" : "mac2";
                for (int j = 0; j < frag.len(); j++)
                    line_bytes.push_back(frag[j]);
                // Skipped byte after the key: usually '=', sometimes anything
                line_bytes.push_back(($urandom_range(0, 3) == 0) ?
                                     8'($urandom_range(0, 255)) : 8'h3D);
                for (int p = 0; p < 3 * ADDRESS_BYTES - 1; p++)
                begin
                    if ($urandom_range(0, 24) == 0)
                        line_bytes.push_back(8'($urandom_range(0, 255)));
                    else if (p % 3 == 2)
                        case ($urandom_range(0, 2))
                            0:       line_bytes.push_back(8'h3A);
                            1:       line_bytes.push_back(8'h2D);
                            default: line_bytes.push_back(8'($urandom_range(1, 255)));
                        endcase
                    else
                    begin
                        nib = 4'($urandom_range(0, 15));
                        if (nib < 10)
                            line_bytes.push_back(8'("0" + nib));
                        else if ($urandom_range(0, 1) == 0)
                            line_bytes.push_back(8'("A" + nib - 10));
                        else
                            line_bytes.push_back(8'("a" + nib - 10));
                    end
                end
            end
            else if (sel <= 7)
            begin
                repeat ($urandom_range(1, 6))
                    line_bytes.push_back(($urandom_range(0, 39) == 0) ?
                                         8'h00 : 8'($urandom_range(1, 255)));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       frag = "m";
                    1:       frag = "ma";
                    2:       frag = "mac";
                    default: frag = "mmac";
                endcase
                for (int j = 0; j < frag.len(); j++)
                    line_bytes.push_back(frag[j]);
            end
        end
        // Cut the line short now and then
        if ($urandom_range(0, 7) == 0)
        begin
            keep = $urandom_range(1, line_bytes.size());
            while (line_bytes.size() > keep)
                void'(line_bytes.pop_back());
        end
    endtask

    // Compare one accepted report with the oldest prediction
    task automatic check_report(input logic [103:0] data);
        mac_report_t exp;
        reports_seen++;
        if (awaited_reports.size() == 0)
        begin
            error_count++;
            $display("%0t: report with none awaited, got %h", $time, data);
        end
        else
        begin
            exp = awaited_reports.pop_front();
            if (data[2:0] !== exp.status)
            begin
                error_count++;
                $display("%0t: status expected %0d, got %0d", $time, exp.status, data[2:0]);
            end
            if (data[50:3] !== exp.first_addr)
            begin
                error_count++;
                $display("%0t: first address expected %h, got %h",
                         $time, exp.first_addr, data[50:3]);
            end
            if (data[98:51] !== exp.second_addr)
            begin
                error_count++;
                $display("%0t: second address expected %h, got %h",
                         $time, exp.second_addr, data[98:51]);
            end
            if (data[103:99] !== 5'h0)
            begin
                error_count++;
                $display("%0t: padding expected 00, got %h", $time, data[103:99]);
            end
        end
    endtask

    // Receiver: take reports, then hold tready low for a drawn number of cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_report(m_tdata);
                if ($urandom_range(0, 5) == 0)
                    rx_idling = !rx_idling;
                rx_wait = rx_idling ? $urandom_range(0, 9) : 0;
                m_tready <= (rx_wait == 0);
            end
            else if (rx_wait > 0)
            begin
                rx_wait = rx_wait - 1;
                m_tready <= (rx_wait == 0);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [7:0]  line_bytes [$];
        logic [7:0]  ch;
        int          random_start;
        mac_report_t none_typed;
        none_typed = '{STATUS_OK, 48'h0, 48'h0};
        clear_parser_state();

        // Hold reset, then release it on an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines: key extremes, each status, hex boundaries, repeated
        // keys, bytes after the end of the string and short captures
        foreach (directed_lines[r])
        begin
            line_bytes = {};
            for (int j = 0; j < directed_lines[r].text.len(); j++)
            begin
                ch = directed_lines[r].text[j];
                line_bytes.push_back((ch == "^") ? 8'h00 : ch);
            end
            send_line(line_bytes, directed_lines[r].typed, directed_lines[r].report);
        end

        // Random lines until enough bytes and lines have been sent
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES ||
               lines_sent < MIN_LINES + $size(directed_lines))
        begin
            compose_command_line(line_bytes);
            send_line(line_bytes, 1'b0, none_typed);
        end

        // Drop valid on the edge that took the last byte
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Drain the remaining reports, then allow for the pipeline
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d command lines (%0d bytes) and checked %0d reports",
                 lines_sent, bytes_sent, reports_seen);
        $display("with random idling on both channels and %0d mismatches", error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
